// ===== rtl/mp2_pkg.sv =====
// shared types, constants and float compare for the max pooling stream
package mp2_pkg;

  localparam int unsigned DEF_MAX_CHANNELS = 64;
  localparam int unsigned DEF_MAX_IN_WIDTH = 1024;
  localparam int unsigned DEF_MAX_STRIDE   = 16;

  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DIM_W     = 16;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [SAMPLE_W-1:0] NEG_INF_BITS = 32'hFF80_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_IN_WIDTH      = 3'd1,
    REG_IN_HEIGHT     = 3'd2,
    REG_WINDOW_STRIDE = 3'd3,
    REG_BATCH_COUNT   = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    DIV_IDLE,
    DIV_OUT_W,
    DIV_OUT_H,
    DIV_COL,
    DIV_ROW
  } div_job_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                first;
    logic                last;
    logic                image_end;
    logic                batch_end;
  } pool_op_t;

  // strict a > b on single precision patterns, false if either is nan
  function automatic logic fp_gt(logic [31:0] a, logic [31:0] b);
    logic a_nan;
    logic b_nan;
    logic both_zero;
    logic res;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    if (a_nan || b_nan || both_zero) begin
      res = 1'b0;
    end else if (!a[31] && b[31]) begin
      res = 1'b1;
    end else if (a[31] && !b[31]) begin
      res = 1'b0;
    end else if (!a[31]) begin
      res = a[30:0] > b[30:0];
    end else begin
      res = a[30:0] < b[30:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/mp2_ram.sv =====
// generic single write port ram with registered read
module mp2_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/mp2_fifo.sv =====
// short request queue between front and back
module mp2_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic             full
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign empty   = (cnt_r == CW'(0));
  assign full    = (cnt_r == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (32'(wp_r) == DEPTH - 1) ? PW'(0) : PW'(32'(wp_r) + 1);
    end
    if (do_pop) begin
      rp_nxt = (32'(rp_r) == DEPTH - 1) ? PW'(0) : PW'(32'(rp_r) + 1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = CW'(32'(cnt_r) + 1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CW'(32'(cnt_r) - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

// ===== rtl/mp2_front.sv =====
// front: registers, stream position, window classification
module mp2_front #(
  parameter int unsigned MAX_CHANNELS = mp2_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned MAX_IN_WIDTH = mp2_pkg::DEF_MAX_IN_WIDTH,
  parameter int unsigned MAX_STRIDE   = mp2_pkg::DEF_MAX_STRIDE,
  parameter int unsigned AW           = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mp2_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mp2_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  input  logic [mp2_pkg::SAMPLE_W-1:0]     in_sample_bits,
  output logic                             in_stall,
  input  logic                             q_full,
  output logic                             q_push,
  output mp2_pkg::pool_op_t                q_op,
  output logic [AW-1:0]                    q_addr
);

  localparam int unsigned CCW = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned WW  = $clog2(MAX_IN_WIDTH + 1);
  localparam int unsigned XW  = (MAX_IN_WIDTH > 1) ? $clog2(MAX_IN_WIDTH) : 1;
  localparam int unsigned SW  = $clog2(MAX_STRIDE + 1);
  localparam int unsigned KW  = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;
  localparam int unsigned DW  = mp2_pkg::DIM_W;

  logic [CCW-1:0] cc_r;
  logic [WW-1:0]  w_r;
  logic [DW-1:0]  h_r, bc_r;
  logic [SW-1:0]  s_r;

  logic [CHW-1:0] ch_r, ch_nxt;
  logic [XW-1:0]  col_r, col_nxt, wx_r, wx_nxt;
  logic [KW-1:0]  kx_r, kx_nxt, ky_r, ky_nxt;
  logic [DW-1:0]  row_r, row_nxt, wy_r, wy_nxt, img_r, img_nxt;
  logic [WW-1:0]  ow_r, ow_nxt;
  logic [DW-1:0]  oh_r, oh_nxt;

  mp2_pkg::div_job_t job_r, job_nxt;
  logic [3:0]     step_r, step_nxt;
  logic [SW-1:0]  rem_r, rem_nxt;
  logic [DW-1:0]  quo_r, quo_nxt;
  logic [DW-1:0]  dvd;
  logic [SW:0]    trial;
  logic           take;
  logic [SW-1:0]  rem_new;
  logic [DW-1:0]  quo_new;

  logic accept, in_win, ch_wrap, col_wrap, row_wrap, kx_wrap, ky_wrap;

  assign in_stall = q_full || (job_r != mp2_pkg::DIV_IDLE);
  assign accept   = in_valid && !in_stall;

  // classification of the current position
  assign in_win = (32'(wx_r) < 32'(ow_r)) && (32'(wy_r) < 32'(oh_r));
  assign q_push = accept && in_win;
  assign q_op.sample    = in_sample_bits;
  assign q_op.first     = (kx_r == KW'(0)) && (ky_r == KW'(0));
  assign q_op.last      = (32'(kx_r) + 1 == 32'(s_r)) && (32'(ky_r) + 1 == 32'(s_r));
  assign q_op.image_end = (32'(wx_r) + 1 == 32'(ow_r)) && (32'(wy_r) + 1 == 32'(oh_r))
                          && (32'(ch_r) + 1 >= 32'(cc_r));
  assign q_op.batch_end = q_op.image_end && (32'(img_r) + 1 >= 32'(bc_r));
  assign q_addr = AW'(32'(wx_r) * MAX_CHANNELS + 32'(ch_r));

  assign ch_wrap  = 32'(ch_r) + 1 >= 32'(cc_r);
  assign col_wrap = 32'(col_r) + 1 >= 32'(w_r);
  assign row_wrap = 32'(row_r) + 1 >= 32'(h_r);
  assign kx_wrap  = 32'(kx_r) + 1 >= 32'(s_r);
  assign ky_wrap  = 32'(ky_r) + 1 >= 32'(s_r);

  // restoring divider step, one quotient bit a cycle
  always_comb begin
    case (job_r)
      mp2_pkg::DIV_OUT_W: dvd = DW'(w_r);
      mp2_pkg::DIV_OUT_H: dvd = h_r;
      mp2_pkg::DIV_COL:   dvd = DW'(col_r);
      mp2_pkg::DIV_ROW:   dvd = row_r;
      default:            dvd = '0;
    endcase
    trial   = {rem_r, dvd[4'(DW - 1) - step_r]};
    take    = trial >= {1'b0, s_r};
    rem_new = take ? SW'(trial - {1'b0, s_r}) : SW'(trial);
    quo_new = {quo_r[DW-2:0], take};
  end

  // position advance and divider sequencing
  always_comb begin
    ch_nxt  = ch_r;
    col_nxt = col_r;
    wx_nxt  = wx_r;
    kx_nxt  = kx_r;
    row_nxt = row_r;
    wy_nxt  = wy_r;
    ky_nxt  = ky_r;
    img_nxt = img_r;
    ow_nxt  = ow_r;
    oh_nxt  = oh_r;
    job_nxt = job_r;
    step_nxt = step_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;

    if (accept) begin
      if (ch_wrap) begin
        ch_nxt = '0;
        if (col_wrap) begin
          col_nxt = '0;
          wx_nxt  = '0;
          kx_nxt  = '0;
          if (row_wrap) begin
            row_nxt = '0;
            wy_nxt  = '0;
            ky_nxt  = '0;
            img_nxt = (32'(img_r) + 1 >= 32'(bc_r)) ? '0 : DW'(32'(img_r) + 1);
          end else begin
            row_nxt = DW'(32'(row_r) + 1);
            if (ky_wrap) begin
              ky_nxt = '0;
              wy_nxt = DW'(32'(wy_r) + 1);
            end else begin
              ky_nxt = KW'(32'(ky_r) + 1);
            end
          end
        end else begin
          col_nxt = XW'(32'(col_r) + 1);
          if (kx_wrap) begin
            kx_nxt = '0;
            wx_nxt = XW'(32'(wx_r) + 1);
          end else begin
            kx_nxt = KW'(32'(kx_r) + 1);
          end
        end
      end else begin
        ch_nxt = CHW'(32'(ch_r) + 1);
      end
    end

    if (job_r != mp2_pkg::DIV_IDLE) begin
      rem_nxt  = rem_new;
      quo_nxt  = quo_new;
      step_nxt = step_r + 4'd1;
      if (step_r == 4'(DW - 1)) begin
        rem_nxt  = '0;
        quo_nxt  = '0;
        step_nxt = '0;
        case (job_r)
          mp2_pkg::DIV_OUT_W: begin
            ow_nxt  = WW'(quo_new);
            job_nxt = mp2_pkg::DIV_OUT_H;
          end
          mp2_pkg::DIV_OUT_H: begin
            oh_nxt  = quo_new;
            job_nxt = mp2_pkg::DIV_COL;
          end
          mp2_pkg::DIV_COL: begin
            wx_nxt  = XW'(quo_new);
            kx_nxt  = KW'(rem_new);
            job_nxt = mp2_pkg::DIV_ROW;
          end
          mp2_pkg::DIV_ROW: begin
            wy_nxt  = quo_new;
            ky_nxt  = KW'(rem_new);
            job_nxt = mp2_pkg::DIV_IDLE;
          end
          default: job_nxt = mp2_pkg::DIV_IDLE;
        endcase
      end
    end

    if (cfg_we) begin
      job_nxt  = mp2_pkg::DIV_OUT_W;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r  <= CCW'(1);
      w_r   <= WW'(1);
      h_r   <= DW'(1);
      s_r   <= SW'(1);
      bc_r  <= DW'(1);
      ch_r  <= '0;
      col_r <= '0;
      wx_r  <= '0;
      kx_r  <= '0;
      row_r <= '0;
      wy_r  <= '0;
      ky_r  <= '0;
      img_r <= '0;
      ow_r  <= WW'(1);
      oh_r  <= DW'(1);
      job_r <= mp2_pkg::DIV_IDLE;
      step_r <= '0;
      rem_r <= '0;
      quo_r <= '0;
    end else begin
      ch_r  <= ch_nxt;
      col_r <= col_nxt;
      wx_r  <= wx_nxt;
      kx_r  <= kx_nxt;
      row_r <= row_nxt;
      wy_r  <= wy_nxt;
      ky_r  <= ky_nxt;
      img_r <= img_nxt;
      ow_r  <= ow_nxt;
      oh_r  <= oh_nxt;
      job_r <= job_nxt;
      step_r <= step_nxt;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      if (cfg_we) begin
        case (mp2_pkg::cfg_reg_t'(cfg_index))
          mp2_pkg::REG_CHANNEL_COUNT:
            cc_r <= (cfg_data == '0) ? CCW'(1) :
                    (32'(cfg_data) > MAX_CHANNELS) ? CCW'(MAX_CHANNELS) : CCW'(cfg_data);
          mp2_pkg::REG_IN_WIDTH:
            w_r <= (cfg_data == '0) ? WW'(1) :
                   (32'(cfg_data) > MAX_IN_WIDTH) ? WW'(MAX_IN_WIDTH) : WW'(cfg_data);
          mp2_pkg::REG_IN_HEIGHT:
            h_r <= (cfg_data == '0) ? DW'(1) : cfg_data;
          mp2_pkg::REG_WINDOW_STRIDE:
            s_r <= (cfg_data == '0) ? SW'(1) :
                   (32'(cfg_data) > MAX_STRIDE) ? SW'(MAX_STRIDE) : SW'(cfg_data);
          mp2_pkg::REG_BATCH_COUNT:
            bc_r <= (cfg_data == '0) ? DW'(1) : cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/mp2_back.sv =====
// back: read-compare-write of running maxima and result register
module mp2_back #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  mp2_pkg::pool_op_t            q_op,
  input  logic [AW-1:0]                q_addr,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mp2_pkg::SAMPLE_W-1:0] out_pooled_bits,
  output logic                         out_image_end,
  output logic                         out_batch_end
);

  localparam int unsigned SMW = mp2_pkg::SAMPLE_W;

  logic              adv;
  logic              s1_v_r;
  mp2_pkg::pool_op_t s1_op_r;
  logic [AW-1:0]     s1_addr_r;
  logic [SMW-1:0]    rdata, old_val, kept;
  logic              wr_v_r;
  logic [AW-1:0]     wr_addr_r;
  logic [SMW-1:0]    wr_data_r;
  logic              ov_r, ov_nxt;
  logic [SMW-1:0]    obits_r;
  logic              oimg_r, obat_r;
  logic              wr_en;

  // whole back pipe moves while the result register can take a value
  assign adv   = !ov_r || !out_stall;
  assign q_pop = adv && !q_empty;
  assign wr_en = adv && s1_v_r;

  mp2_ram #(.WIDTH(SMW), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr_r),
    .wdata (kept),
    .re    (adv),
    .raddr (q_addr),
    .rdata (rdata)
  );

  // newest write wins over the ram read issued alongside it
  always_comb begin
    if (s1_op_r.first) begin
      old_val = mp2_pkg::NEG_INF_BITS;
    end else if (wr_v_r && (wr_addr_r == s1_addr_r)) begin
      old_val = wr_data_r;
    end else begin
      old_val = rdata;
    end
    kept   = mp2_pkg::fp_gt(s1_op_r.sample, old_val) ? s1_op_r.sample : old_val;
    ov_nxt = adv ? (s1_v_r && s1_op_r.last) : ov_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      wr_v_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (adv) begin
        s1_v_r <= !q_empty;
      end
      if (wr_en) begin
        wr_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r   <= q_op;
      s1_addr_r <= q_addr;
      obits_r   <= kept;
      oimg_r    <= s1_op_r.image_end;
      obat_r    <= s1_op_r.batch_end;
    end
    if (wr_en) begin
      wr_addr_r <= s1_addr_r;
      wr_data_r <= kept;
    end
  end

  assign out_valid       = ov_r;
  assign out_pooled_bits = obits_r;
  assign out_image_end   = oimg_r;
  assign out_batch_end   = obat_r;

endmodule

// ===== rtl/max_pool_2d_stream.sv =====
// top level of the streaming non-overlapping 2-d max pooling block
//
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | in_sample_bits
// out     | output    | out_valid/out_stall| out_pooled_bits, out_image_end, out_batch_end
// cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// one element per cycle sustained while in_stall is low; a result is registered
// once its window's last element has passed the queue, store read, compare and write
// each register write starts a divider run (one quotient bit a cycle over
// four divisions) during which in_stall is high
// reset is synchronous, active low; the running-max store needs no clearing
// out_stall holds the back pipe only; the front keeps taking requests until
// the four-entry queue fills
module max_pool_2d_stream #(
  parameter int unsigned MAX_CHANNELS = mp2_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned MAX_IN_WIDTH = mp2_pkg::DEF_MAX_IN_WIDTH,
  parameter int unsigned MAX_STRIDE   = mp2_pkg::DEF_MAX_STRIDE
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mp2_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mp2_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mp2_pkg::SAMPLE_W-1:0]  in_sample_bits,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mp2_pkg::SAMPLE_W-1:0]  out_pooled_bits,
  output logic                          out_image_end,
  output logic                          out_batch_end
);

  // one store entry per window column and channel
  localparam int unsigned DEPTH = MAX_CHANNELS * MAX_IN_WIDTH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OPW   = $bits(mp2_pkg::pool_op_t);
  localparam int unsigned QW    = OPW + AW;

  logic              q_push, q_pop, q_full, q_empty;
  mp2_pkg::pool_op_t f_op, b_op;
  logic [AW-1:0]     f_addr, b_addr;
  logic [QW-1:0]     q_head;

  // front: registers, position counters and window classification
  mp2_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_IN_WIDTH (MAX_IN_WIDTH),
    .MAX_STRIDE   (MAX_STRIDE),
    .AW           (AW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_sample_bits (in_sample_bits),
    .in_stall       (in_stall),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_op           (f_op),
    .q_addr         (f_addr)
  );

  // requests that fall inside a whole window are queued for the back
  mp2_fifo #(.WIDTH(QW), .DEPTH(mp2_pkg::FIFO_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_op, f_addr}),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign b_op   = mp2_pkg::pool_op_t'(q_head[QW-1:AW]);
  assign b_addr = q_head[AW-1:0];

  // back: running max update and result register
  mp2_back #(.DEPTH(DEPTH), .AW(AW)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_op            (b_op),
    .q_addr          (b_addr),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pooled_bits (out_pooled_bits),
    .out_image_end   (out_image_end),
    .out_batch_end   (out_batch_end)
  );

endmodule

// ===== rtl/mp2_checker.sv =====
// port-level checks for the max pooling stream
module mp2_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          cfg_we,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [mp2_pkg::SAMPLE_W-1:0]  out_pooled_bits,
  input logic                          out_image_end,
  input logic                          out_batch_end
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pooled_bits)
      && $stable(out_image_end) && $stable(out_batch_end))
    else $error("stalled result changed");

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result right after reset");

  a_batch_img: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_batch_end |-> out_image_end)
    else $error("batch end without image end");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("request taken during register recompute");

endmodule

bind max_pool_2d_stream mp2_checker u_mp2_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .cfg_we          (cfg_we),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_pooled_bits (out_pooled_bits),
  .out_image_end   (out_image_end),
  .out_batch_end   (out_batch_end)
);
